### hdl/sbfd_pkg.sv
// ----------------------------------------------------------------------------
// sbfd_pkg: types and codes of the sparse bitmask field deserializer
// Beat payload structs for the byte input and the result output, result kinds.
// ----------------------------------------------------------------------------
package sbfd_pkg;

    localparam int unsigned INDEX_W = 11;
    localparam int unsigned WIDX_W  = 6;

    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start_req;
        logic [15:0] field_limit;
        logic        skip_mode;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         kind;
        logic [INDEX_W-1:0] fld_index;
        logic [31:0]        field_value;
        logic               last;
    } t_out_beat;

endpackage

### hdl/sparse_bitmask_field_deserializer.sv
// ----------------------------------------------------------------------------
// sparse_bitmask_field_deserializer
// Parses one sparse field record from a byte stream and emits indexed values.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle, with no gaps of its own, unless the
// input is stalled: each byte beat is absorbed as it arrives and a result
// is registered on the byte that completes it (value, done or error), so
// one byte leaves at most one result beat, in the cycle after it. The input
// stalls only while a result is held in the output register and the output
// side is stalled. Mask words live in a MAX_BLOCKS x 32 synchronous RAM; a
// flop vector marks the nonempty words and priority encoders pick the next
// set bit. The next mask word is read from RAM on the byte that empties
// the previous word, well inside the four bytes of the following value.
module sparse_bitmask_field_deserializer #(
    parameter int unsigned MAX_BLOCKS = 42
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sbfd_pkg::t_in_beat   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sbfd_pkg::t_out_beat  o_out_data
);

    localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned WIDX_EXT = sbfd_pkg::WIDX_W;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_MASK   = 2'd1;
    localparam logic [1:0] PH_VALUES = 2'd2;

    // {found, index} of the lowest set bit
    function automatic logic [AW:0] f_first(input logic [MAX_BLOCKS-1:0] v);
        logic [AW:0] res;
        res = '0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
            if (v[i]) begin
                res = {1'b1, AW'(i)};
            end
        end
        return res;
    endfunction

    // mask word store
    logic [31:0]   mem [MAX_BLOCKS];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;
    logic [AW-1:0] mem_ra;
    logic [31:0]   r_rd_data;

    logic [1:0]            r_phase,     n_phase;
    logic [MAX_BLOCKS-1:0] r_nonempty,  n_nonempty;
    logic [5:0]            r_declared,  n_declared;
    logic [AW-1:0]         r_count,     n_count;
    logic [1:0]            r_byte_idx,  n_byte_idx;
    logic [23:0]           r_asm,       n_asm;
    logic [15:0]           r_bound,     n_bound;
    logic                  r_discard,   n_discard;
    logic [AW-1:0]         r_cur_widx,  n_cur_widx;
    logic [31:0]           r_cur_word,  n_cur_word;
    logic                  r_load_pend, n_load_pend;
    logic                  r_out_valid, n_out_valid;
    sbfd_pkg::t_out_beat   r_out,       n_out;

    logic                  accept;
    logic [31:0]           full_word;
    logic [15:0]           base;
    logic [15:0]           lim;
    logic [31:0]           masked;
    logic [MAX_BLOCKS-1:0] ne_with_new;
    logic [MAX_BLOCKS-1:0] ne_cleared;
    logic [AW:0]           first_new;
    logic [AW:0]           first_clr;
    logic [4:0]            low_bit;
    logic [31:0]           word_clr;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign full_word = {i_in_data.data_byte, r_asm};

    // read mode drops mask bits at or above the field bound
    always_comb begin
        base   = 16'(r_count) << 5;
        lim    = (r_bound > base) ? (r_bound - base) : 16'd0;
        masked = full_word;
        if (!r_discard && lim < 16'd32) begin
            masked = full_word & ((32'h1 << lim[4:0]) - 32'h1);
        end
    end

    assign ne_with_new = r_nonempty |
                         ((masked != 32'h0) ? (MAX_BLOCKS'(1) << r_count) : '0);
    assign first_new   = f_first(ne_with_new);
    assign ne_cleared  = r_nonempty & ~(MAX_BLOCKS'(1) << r_cur_widx);
    assign first_clr   = f_first(ne_cleared);

    always_comb begin
        low_bit = 5'd0;
        for (int b = 31; b >= 0; b--) begin
            if (r_cur_word[b]) begin
                low_bit = 5'(b);
            end
        end
    end

    assign word_clr = r_cur_word & ~(32'h1 << low_bit);

    always_comb begin
        n_phase     = r_phase;
        n_nonempty  = r_nonempty;
        n_declared  = r_declared;
        n_count     = r_count;
        n_byte_idx  = r_byte_idx;
        n_asm       = r_asm;
        n_bound     = r_bound;
        n_discard   = r_discard;
        n_cur_widx  = r_cur_widx;
        n_cur_word  = r_cur_word;
        n_load_pend = 1'b0;
        n_out_valid = r_out_valid & i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_wa      = r_count;
        mem_wd      = masked;
        mem_ra      = first_new[AW-1:0];

        if (r_load_pend) begin
            n_cur_word = r_rd_data;
        end

        if (accept) begin
            if (i_in_data.start_req) begin
                n_count    = '0;
                n_byte_idx = 2'd0;
                n_nonempty = '0;
                n_bound    = i_in_data.field_limit;
                n_discard  = i_in_data.skip_mode;
                if (i_in_data.data_byte > 8'(MAX_BLOCKS)) begin
                    n_declared  = 6'd0;
                    n_phase     = PH_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '{kind: sbfd_pkg::KIND_ERROR, fld_index: '0,
                                    field_value: '0, last: 1'b1};
                end else if (i_in_data.data_byte == 8'd0) begin
                    n_declared  = 6'd0;
                    n_phase     = PH_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '{kind: sbfd_pkg::KIND_DONE, fld_index: '0,
                                    field_value: '0, last: 1'b1};
                end else begin
                    n_declared = i_in_data.data_byte[5:0];
                    n_phase    = PH_MASK;
                end
            end else if (r_phase == PH_MASK) begin
                if (r_byte_idx != 2'd3) begin
                    n_asm[{r_byte_idx, 3'b000} +: 8] = i_in_data.data_byte;
                    n_byte_idx = r_byte_idx + 2'd1;
                end else begin
                    n_byte_idx = 2'd0;
                    mem_we     = 1'b1;
                    n_nonempty = ne_with_new;
                    n_count    = r_count + AW'(1);
                    if (6'(r_count) + 6'd1 == r_declared) begin
                        if (first_new[AW]) begin
                            n_phase    = PH_VALUES;
                            n_cur_widx = first_new[AW-1:0];
                            // first word may be the one written this cycle
                            if (first_new[AW-1:0] == r_count) begin
                                n_cur_word = masked;
                            end else begin
                                n_load_pend = 1'b1;
                            end
                        end else begin
                            n_phase     = PH_IDLE;
                            n_out_valid = 1'b1;
                            n_out       = '{kind: sbfd_pkg::KIND_DONE, fld_index: '0,
                                            field_value: '0, last: 1'b1};
                        end
                    end
                end
            end else if (r_phase == PH_VALUES) begin
                if (r_byte_idx != 2'd3) begin
                    n_asm[{r_byte_idx, 3'b000} +: 8] = i_in_data.data_byte;
                    n_byte_idx = r_byte_idx + 2'd1;
                end else begin
                    n_byte_idx = 2'd0;
                    if (word_clr != 32'h0) begin
                        n_cur_word = word_clr;
                    end else begin
                        n_nonempty = ne_cleared;
                        if (first_clr[AW]) begin
                            n_cur_widx  = first_clr[AW-1:0];
                            mem_ra      = first_clr[AW-1:0];
                            n_load_pend = 1'b1;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    if (!r_discard) begin
                        n_out_valid = 1'b1;
                        n_out       = '{kind: sbfd_pkg::KIND_VALUE,
                                        fld_index: {WIDX_EXT'(r_cur_widx), low_bit},
                                        field_value: full_word,
                                        last: (word_clr == 32'h0) && !first_clr[AW]};
                    end else if (word_clr == 32'h0 && !first_clr[AW]) begin
                        n_out_valid = 1'b1;
                        n_out       = '{kind: sbfd_pkg::KIND_DONE, fld_index: '0,
                                        field_value: '0, last: 1'b1};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_nonempty  <= '0;
            r_declared  <= 6'd0;
            r_count     <= '0;
            r_byte_idx  <= 2'd0;
            r_bound     <= 16'd0;
            r_discard   <= 1'b0;
            r_cur_widx  <= '0;
            r_load_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_nonempty  <= n_nonempty;
            r_declared  <= n_declared;
            r_count     <= n_count;
            r_byte_idx  <= n_byte_idx;
            r_bound     <= n_bound;
            r_discard   <= n_discard;
            r_cur_widx  <= n_cur_widx;
            r_load_pend <= n_load_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_asm      <= n_asm;
        r_cur_word <= n_cur_word;
        r_out      <= n_out;
    end

    a_load_in_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_pend |-> r_phase == PH_VALUES)
        else $error("mask word fetch outside value phase");

    a_cur_word_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VALUES && !r_load_pend) |-> r_cur_word != 32'h0)
        else $error("current mask word empty in value phase");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result held");

    a_final_kinds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind != sbfd_pkg::KIND_VALUE) |-> o_out_data.last)
        else $error("done or error beat without last");

endmodule
